[rtl/sasd_pkg.sv]
`default_nettype none
package sasd_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GUARD_BITS      = 16;
  localparam int COUNT_WIDTH     = 8;
  localparam int FRAC_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION_COUNT   = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADZONE_FRACTION = 8'd1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 8'd8;
  localparam logic [FRAC_WIDTH-1:0]  FRAC_RESET  = 16'd0;

  // 1 / CORDIC gain, Q1.30
  localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn32(input int i);
    case (i)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10680862;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      28: return 32'd3;
      29: return 32'd1;
      30: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

  // round half up to aw bits of angle
  function automatic logic [31:0] atan_step(input int i, input int aw);
    logic [32:0] t;
    int s;
    t = {1'b0, atan_turn32(i & 31)};
    s = 32 - aw;
    if (s == 0) return t[31:0];
    return 32'((t + (33'd1 << (s - 1))) >> s);
  endfunction

endpackage
`default_nettype wire

[rtl/sasd_in_if.sv]
`default_nettype none
interface sasd_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_in;
  logic signed [SAMPLE_WIDTH-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface
`default_nettype wire

[rtl/sasd_out_if.sv]
`default_nettype none
interface sasd_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_out;
  logic signed [SAMPLE_WIDTH-1:0] y_out;
  logic                           snapped;

  modport source (output valid, output x_out, output y_out, output snapped, input ready);
  modport sink (input valid, input x_out, input y_out, input snapped, output ready);
endinterface
`default_nettype wire

[rtl/stick_angular_snap_deadzone.sv]
`default_nettype none
// Path: vector CORDIC, snap and divider stages, rotation CORDIC, then the output
//   register, where a result may wait until it is taken.
// Throughput: one sample per cycle; the pipeline and its divider take a new
//   request every cycle and stall as a whole only when the output skid buffer is full.
// Reset (rst_n low, synchronous): direction count 8, deadzone fraction 0,
//   all pipeline and output valid bits cleared.
module stick_angular_snap_deadzone
  import sasd_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  sasd_in_if.sink                         in_ch,
  sasd_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = ANGLE_WIDTH;

  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [FRAC_WIDTH-1:0]  dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= COUNT_RESET;
      dz_r  <= FRAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION_COUNT: begin
          // drop a zero count
          if (cfg_data[COUNT_WIDTH-1:0] != '0) cnt_r <= cfg_data[COUNT_WIDTH-1:0];
        end
        REG_DEADZONE_FRACTION: begin
          dz_r <= cfg_data[FRAC_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic en;
  logic skid_valid_r;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  logic                 vv;
  logic signed [SW-1:0] vx, vy;
  logic [AW-1:0]        vz;
  logic                 vzero;

  sasd_vector #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_vector (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .x_in      (in_ch.x_in),
    .y_in      (in_ch.y_in),
    .out_valid (vv),
    .x_o       (vx),
    .y_o       (vy),
    .z_o       (vz),
    .zero_o    (vzero)
  );

  logic                 sv, sneg, ssnap;
  logic signed [SW-1:0] sx, sy;
  logic signed [AW-1:0] sa;
  logic [AW:0]          sdir;

  sasd_snap #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH)
  ) u_snap (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cnt       (cnt_r),
    .dz        (dz_r),
    .in_valid  (vv),
    .x_i       (vx),
    .y_i       (vy),
    .z_i       (vz),
    .zero_i    (vzero),
    .out_valid (sv),
    .x_o       (sx),
    .y_o       (sy),
    .a_o       (sa),
    .dir_o     (sdir),
    .neg_o     (sneg),
    .snap_o    (ssnap)
  );

  logic                 rv, rsnap;
  logic signed [SW-1:0] rx, ry;

  sasd_rotate #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sv),
    .x_i       (sx),
    .y_i       (sy),
    .a_i       (sa),
    .dir_i     (sdir),
    .neg_i     (sneg),
    .snap_i    (ssnap),
    .out_valid (rv),
    .x_o       (rx),
    .y_o       (ry),
    .snap_o    (rsnap)
  );

  // output register with skid stage
  logic                 out_valid_r;
  logic signed [SW-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                 out_snap_r, skid_snap_r;
  logic                 out_take, arrive;

  assign out_take = out_valid_r && out_ch.ready;
  assign arrive   = rv && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) skid_valid_r <= 1'b0;
    end else if (arrive) begin
      if (out_valid_r && !out_take) skid_valid_r <= 1'b1;
      else                          out_valid_r  <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_snap_r <= skid_snap_r;
      end
    end else if (arrive) begin
      if (out_valid_r && !out_take) begin
        skid_x_r    <= rx;
        skid_y_r    <= ry;
        skid_snap_r <= rsnap;
      end else begin
        out_x_r    <= rx;
        out_y_r    <= ry;
        out_snap_r <= rsnap;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.x_out   = out_x_r;
  assign out_ch.y_out   = out_y_r;
  assign out_ch.snapped = out_snap_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r)
    else $error("skid stage drained without an output transfer");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r != '0)
    else $error("direction count became zero");
`endif

endmodule
`default_nettype wire

[rtl/sasd_vector.sv]
`default_nettype none
module sasd_vector
  import sasd_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_in,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      x_o,
  output logic signed [SAMPLE_WIDTH-1:0]      y_o,
  output logic [ANGLE_WIDTH-1:0]              z_o,
  output logic                                zero_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int NS = CORDIC_STAGES;
  localparam int VW = SW + GUARD_BITS + 3;

  logic                 valid_r [0:NS];
  logic signed [VW-1:0] vx_r    [0:NS];
  logic signed [VW-1:0] vy_r    [0:NS];
  logic [AW-1:0]        z_r     [0:NS];
  logic signed [SW-1:0] x_r     [0:NS];
  logic signed [SW-1:0] y_r     [0:NS];
  logic                 zero_r  [0:NS];

  logic signed [VW-1:0] xs, ys;
  logic                 neg;

  assign xs  = {{(VW-SW-GUARD_BITS){x_in[SW-1]}}, x_in, {GUARD_BITS{1'b0}}};
  assign ys  = {{(VW-SW-GUARD_BITS){y_in[SW-1]}}, y_in, {GUARD_BITS{1'b0}}};
  assign neg = x_in[SW-1];

  // fold the left half plane onto the right, starting from a half turn
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0]   <= neg ? -xs : xs;
      vy_r[0]   <= neg ? -ys : ys;
      z_r[0]    <= {neg, {(AW-1){1'b0}}};
      x_r[0]    <= x_in;
      y_r[0]    <= y_in;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [31:0] ATAN32 = atan_step(i, AW);
    logic signed [VW-1:0] dx, dy;

    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][VW-1]) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + ATAN32[AW-1:0];
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - ATAN32[AW-1:0];
        end
        x_r[i+1]    <= x_r[i];
        y_r[i+1]    <= y_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
    end
  end

  assign out_valid = valid_r[NS];
  assign x_o       = x_r[NS];
  assign y_o       = y_r[NS];
  assign z_o       = z_r[NS];
  assign zero_o    = zero_r[NS];

endmodule
`default_nettype wire

[rtl/sasd_snap.sv]
`default_nettype none
module sasd_snap
  import sasd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic [COUNT_WIDTH-1:0]         cnt,
  input  wire logic [FRAC_WIDTH-1:0]          dz,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_i,
  input  wire logic [ANGLE_WIDTH-1:0]         z_i,
  input  wire logic                           zero_i,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      x_o,
  output logic signed [SAMPLE_WIDTH-1:0]      y_o,
  output logic signed [ANGLE_WIDTH-1:0]       a_o,
  output logic [ANGLE_WIDTH:0]                dir_o,
  output logic                                neg_o,
  output logic                                snap_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int MW = AW + COUNT_WIDTH;     // |angle| * count
  localparam int KW = COUNT_WIDTH + 1;      // direction index
  localparam int EW = AW + KW;              // distance to direction
  localparam int NW = AW + KW + 1;          // dividend
  localparam int RW = COUNT_WIDTH + 1;      // divisor and remainder

  // stage 1: |angle| * count
  logic                 v1_r;
  logic signed [SW-1:0] x1_r, y1_r;
  logic signed [AW-1:0] a1_r;
  logic [MW-1:0]        mc1_r;
  logic signed [AW-1:0] a_in;
  logic [AW-1:0]        mag;

  assign a_in = zero_i ? '0 : $signed(z_i);
  assign mag  = a_in[AW-1] ? AW'(-a_in) : AW'(a_in);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x_i;
      y1_r  <= y_i;
      a1_r  <= a_in;
      mc1_r <= MW'(mag) * MW'(cnt);
    end
  end

  // stage 2: nearest direction and distance to it
  logic                 v2_r;
  logic signed [SW-1:0] x2_r, y2_r;
  logic signed [AW-1:0] a2_r;
  logic [KW-1:0]        k2_r;
  logic [EW-1:0]        diff2_r;
  logic [EW-1:0]        sum, kt;
  logic [KW-1:0]        k;

  assign sum = EW'(mc1_r) + (EW'(1) << (AW - 1));
  assign k   = sum[EW-1:AW];
  assign kt  = {k, {AW{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      a2_r    <= a1_r;
      k2_r    <= k;
      diff2_r <= (kt >= EW'(mc1_r)) ? kt - EW'(mc1_r) : EW'(mc1_r) - kt;
    end
  end

  // stage 3: deadzone compare, load divider
  logic [EW+FRAC_WIDTH-1:0] lhs, rhs;
  logic [RW-1:0]            dvs;

  assign lhs = {diff2_r, {FRAC_WIDTH{1'b0}}};
  assign rhs = {{KW{1'b0}}, dz, {AW{1'b0}}};
  assign dvs = {cnt, 1'b0};

  logic                 valid_r [0:NW];
  logic signed [SW-1:0] x_r     [0:NW];
  logic signed [SW-1:0] y_r     [0:NW];
  logic signed [AW-1:0] a_r     [0:NW];
  logic                 snap_r  [0:NW];
  logic [NW-1:0]        nq_r    [0:NW];
  logic [RW-1:0]        rem_r   [0:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x2_r;
      y_r[0]    <= y2_r;
      a_r[0]    <= a2_r;
      snap_r[0] <= lhs < rhs;
      // dividend 2*k*turn + count, divisor 2*count
      nq_r[0]   <= {k2_r, (AW+1)'(cnt)};
      rem_r[0]  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      valid_r[0] <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      v2_r       <= v1_r;
      valid_r[0] <= v2_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [RW:0] remw;
    logic        ge;

    assign remw = {rem_r[j], nq_r[j][NW-1]};
    assign ge   = remw >= {1'b0, dvs};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? RW'(remw - {1'b0, dvs}) : remw[RW-1:0];
        nq_r[j+1]   <= {nq_r[j][NW-2:0], ge};
        x_r[j+1]    <= x_r[j];
        y_r[j+1]    <= y_r[j];
        a_r[j+1]    <= a_r[j];
        snap_r[j+1] <= snap_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j+1] <= 1'b0;
      end else if (en) begin
        valid_r[j+1] <= valid_r[j];
      end
    end
  end

  assign out_valid = valid_r[NW];
  assign x_o       = x_r[NW];
  assign y_o       = y_r[NW];
  assign a_o       = a_r[NW];
  assign dir_o     = nq_r[NW][AW:0];
  assign neg_o     = a_r[NW][AW-1];
  assign snap_o    = snap_r[NW];

endmodule
`default_nettype wire

[rtl/sasd_rotate.sv]
`default_nettype none
module sasd_rotate
  import sasd_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_i,
  input  wire logic signed [ANGLE_WIDTH-1:0]  a_i,
  input  wire logic [ANGLE_WIDTH:0]           dir_i,
  input  wire logic                           neg_i,
  input  wire logic                           snap_i,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      x_o,
  output logic signed [SAMPLE_WIDTH-1:0]      y_o,
  output logic                                snap_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int NS  = CORDIC_STAGES;
  localparam int DW  = AW + 3;
  localparam int PW  = SW + GUARD_BITS + 3;
  localparam int MPW = SW + 32;
  localparam int SH  = 30 - GUARD_BITS;
  localparam int FW  = PW - GUARD_BITS;

  localparam logic signed [MPW-1:0] PRE_RND = MPW'(longint'(1) << (SH - 1));
  localparam logic signed [DW-1:0]  QUARTER = DW'(longint'(1) << (AW - 2));
  localparam logic signed [DW-1:0]  HALF    = DW'(longint'(1) << (AW - 1));
  localparam logic signed [PW-1:0]  FIN_RND = PW'(longint'(1) << (GUARD_BITS - 1));
  localparam logic signed [FW-1:0]  SMAX    = FW'((longint'(1) << (SW - 1)) - 1);
  localparam logic signed [FW-1:0]  SMIN    = -FW'(longint'(1) << (SW - 1));
  localparam logic signed [31:0]    INV_S   = {1'b0, INV_GAIN_Q30};

  // stage 1: angle to turn, gain precompensation
  logic                  v1_r, snap1_r;
  logic signed [SW-1:0]  x1_r, y1_r;
  logic signed [MPW-1:0] mx1_r, my1_r;
  logic signed [DW-1:0]  d1_r;
  logic signed [DW-1:0]  dirs;

  assign dirs = neg_i ? -DW'(dir_i) : DW'(dir_i);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x_i;
      y1_r    <= y_i;
      snap1_r <= snap_i;
      mx1_r   <= MPW'(x_i) * MPW'(INV_S);
      my1_r   <= MPW'(y_i) * MPW'(INV_S);
      d1_r    <= dirs - DW'(a_i);
    end
  end

  // stage 2: round into guard bits, fold into the right half of the circle
  logic                 valid_r [0:NS];
  logic signed [SW-1:0] x_r     [0:NS];
  logic signed [SW-1:0] y_r     [0:NS];
  logic                 snap_r  [0:NS];
  logic signed [PW-1:0] px_r    [0:NS];
  logic signed [PW-1:0] py_r    [0:NS];
  logic signed [DW-1:0] dl_r    [0:NS];
  logic signed [PW-1:0] pxs, pys;

  assign pxs = PW'((mx1_r + PRE_RND) >>> SH);
  assign pys = PW'((my1_r + PRE_RND) >>> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x1_r;
      y_r[0]    <= y1_r;
      snap_r[0] <= snap1_r;
      if (d1_r > QUARTER) begin
        px_r[0] <= -pxs;
        py_r[0] <= -pys;
        dl_r[0] <= d1_r - HALF;
      end else if (d1_r < -QUARTER) begin
        px_r[0] <= -pxs;
        py_r[0] <= -pys;
        dl_r[0] <= d1_r + HALF;
      end else begin
        px_r[0] <= pxs;
        py_r[0] <= pys;
        dl_r[0] <= d1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      valid_r[0] <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      valid_r[0] <= v1_r;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [31:0]          ATAN32 = atan_step(i, AW);
    localparam logic signed [DW-1:0] ATAN_D = DW'(ATAN32[AW-1:0]);
    logic signed [PW-1:0] dx, dy;

    assign dx = py_r[i] >>> i;
    assign dy = px_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!dl_r[i][DW-1]) begin
          px_r[i+1] <= px_r[i] - dx;
          py_r[i+1] <= py_r[i] + dy;
          dl_r[i+1] <= dl_r[i] - ATAN_D;
        end else begin
          px_r[i+1] <= px_r[i] + dx;
          py_r[i+1] <= py_r[i] - dy;
          dl_r[i+1] <= dl_r[i] + ATAN_D;
        end
        x_r[i+1]    <= x_r[i];
        y_r[i+1]    <= y_r[i];
        snap_r[i+1] <= snap_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
    end
  end

  // final stage: round, saturate, pick rotated or original sample
  logic                 vf_r;
  logic signed [SW-1:0] xf_r, yf_r;
  logic                 snapf_r;
  logic signed [FW-1:0] rx, ry;
  logic signed [SW-1:0] sx, sy;

  assign rx = FW'((px_r[NS] + FIN_RND) >>> GUARD_BITS);
  assign ry = FW'((py_r[NS] + FIN_RND) >>> GUARD_BITS);

  always_comb begin
    if (rx > SMAX)      sx = SMAX[SW-1:0];
    else if (rx < SMIN) sx = SMIN[SW-1:0];
    else                sx = rx[SW-1:0];
    if (ry > SMAX)      sy = SMAX[SW-1:0];
    else if (ry < SMIN) sy = SMIN[SW-1:0];
    else                sy = ry[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xf_r    <= snap_r[NS] ? sx : x_r[NS];
      yf_r    <= snap_r[NS] ? sy : y_r[NS];
      snapf_r <= snap_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= valid_r[NS];
    end
  end

  assign out_valid = vf_r;
  assign x_o       = xf_r;
  assign y_o       = yf_r;
  assign snap_o    = snapf_r;

endmodule
`default_nettype wire
